[rtl/core/bn_pkg.sv]
// Package for the batch normalization block: widths, codes, state type.
// No dependencies.
`default_nettype none
package bn_pkg;
  localparam int CHANNELS_DEF = 256;
  localparam int CH_W         = 8;
  localparam int SQ_W         = 49;   // (var+eps)<<16 fits in 49 bits
  localparam int ROOT_W       = 25;
  localparam int NUM_W        = 41;   // |(x-mean)*scale*256| < 2^41
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_NORM  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_SQRT, ST_DIV, ST_BIAS, ST_OUT
  } bn_state_t;
endpackage
`default_nettype wire

[rtl/core/bn_if.sv]
// Valid/ready channel interfaces for the batch normalization block.
// Depends on nothing.
`default_nettype none
interface bn_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         channel;
  logic signed [15:0] sample;
  logic signed [15:0] mean_in;
  logic [31:0]        variance_in;
  logic signed [15:0] gain_in;
  logic signed [15:0] offset_in;
  modport source (output valid, func, channel, sample, mean_in, variance_in,
                  gain_in, offset_in, input ready);
  modport sink (input valid, func, channel, sample, mean_in, variance_in,
                gain_in, offset_in, output ready);
endinterface

interface bn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normalized;
  logic               overflow;
  logic               divide_error;
  modport source (output valid, normalized, overflow, divide_error, input ready);
  modport sink (input valid, normalized, overflow, divide_error, output ready);
endinterface

interface bn_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/batch_norm_inference.sv]
// Top level of the fixed point batch normalization block.
// Depends on bn_pkg, bn_if and bn_shared_unit.
`default_nettype none
// A load item (func 0) writes one channel's mean, scale, bias and variance
// in the cycle it is taken; the input stays ready. A normalize item computes
// r = floor(sqrt((variance + epsilon) << 16)), divides (sample - mean) *
// scale * 256 by r with truncation toward zero, adds the bias and saturates.
// It runs on one shared compare/subtract unit: one memory read, a multiply,
// 25 square root steps, 41 division steps and a bias/saturate step, after
// which the result is offered. A zero root skips the division and sets
// divide_error; a channel at or above CHANNELS skips root and division and
// returns zeros. The input is not ready until the result is taken. The
// epsilon register is always ready; the user must write it only while no
// item is in flight, as the block itself does not enforce this. The
// parameter memories are not cleared; normalizing an unloaded channel
// returns undefined values.
module batch_norm_inference
  import bn_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  bn_in_if.sink    in_ch,
  bn_out_if.source out_ch,
  bn_cfg_if.sink   cfg_ch
);
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAD_W = 2 * ROOT_W;

  logic [47:0] aff_mem [CHANNELS];
  logic [31:0] var_mem [CHANNELS];

  bn_state_t state_r, state_nxt;
  logic [15:0] eps_r;
  logic signed [15:0] x_r;
  logic [CH_W-1:0] ch_r;
  logic [47:0] aff_r;
  logic [31:0] var_r;
  logic inrange_r;
  logic [SQ_W+1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [NUM_W-1:0] mag_r, mag_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic neg_r, neg_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic ovf_r, ovf_nxt, dz_r, dz_nxt;

  logic [SQ_W+1:0] trial, u_rem;
  logic u_take;
  logic [AW-1:0] wr_idx, rd_idx;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.normalized   = res_r;
  assign out_ch.overflow     = ovf_r;
  assign out_ch.divide_error = dz_r;

  wire acc = in_ch.valid && in_ch.ready;
  wire in_rng = ({{(32-CH_W){1'b0}}, in_ch.channel} < 32'(CHANNELS));

  assign wr_idx = AW'(in_ch.channel);
  assign rd_idx = AW'(ch_r);

  // Write and read the parameter memories
  always_ff @(posedge clk) begin
    if (acc && in_ch.func == FUNC_LOAD && in_rng) begin
      aff_mem[wr_idx] <= {in_ch.offset_in, in_ch.gain_in, in_ch.mean_in};
      var_mem[wr_idx] <= in_ch.variance_in;
    end
    aff_r <= aff_mem[rd_idx];
    var_r <= var_mem[rd_idx];
  end

  // Hold the item fields
  always_ff @(posedge clk) begin
    if (acc) begin
      x_r <= in_ch.sample;
      ch_r <= in_ch.channel;
      inrange_r <= in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) eps_r <= 16'd1;
    else if (cfg_ch.valid && cfg_ch.ready) eps_r <= cfg_ch.data;
  end

  // Shared step trial: root uses (root<<2|1) pattern, division uses the root as divisor against the shifted remainder
  wire [SQ_W-1:0] sq_in = {{(SQ_W-33){1'b0}}, ({1'b0, var_r} + {17'd0, eps_r})} << 16;
  wire [ROOT_W+1:0] rt_trial = {root_r, 2'b01};
  always_comb begin
    if (state_r == ST_SQRT)
      trial = {{(SQ_W-ROOT_W){1'b0}}, rt_trial};
    else
      trial = {{(SQ_W+2-ROOT_W){1'b0}}, root_r};
  end
  wire [SQ_W+1:0] sq_shift = {rem_r[SQ_W-1:0], rad_r[RAD_W-1 -: 2]};
  wire [SQ_W+1:0] dv_shift = {rem_r[SQ_W:0], mag_r[NUM_W-1]};
  bn_shared_unit u_unit (
    .rem_i   ((state_r == ST_SQRT) ? sq_shift : dv_shift),
    .trial_i (trial),
    .rem_o   (u_rem),
    .take_o  (u_take)
  );

  // Sequencer
  logic signed [16:0] diff;
  logic signed [32:0] prod;
  logic [32:0] pabs;
  logic signed [NUM_W+1:0] qs, vs;
  always_comb begin
    state_nxt = state_r;
    rem_nxt = rem_r; root_nxt = root_r; rad_nxt = rad_r; mag_nxt = mag_r;
    quo_nxt = quo_r; neg_nxt = neg_r; cnt_nxt = cnt_r;
    res_nxt = res_r; ovf_nxt = ovf_r; dz_nxt = dz_r;
    diff = 17'(x_r) - 17'($signed(aff_r[15:0]));
    prod = 33'(diff) * 33'($signed(aff_r[31:16]));
    pabs = prod[32] ? 33'(-prod) : 33'(prod);
    qs = '0; vs = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc && in_ch.func == FUNC_NORM) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (!inrange_r) begin
          // Channel out of range: answer zeros at once
          res_nxt = '0; ovf_nxt = 1'b0; dz_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          // Multiply, keep the magnitude as dividend, load the radicand
          neg_nxt = prod[32];
          mag_nxt = NUM_W'(pabs) << 8;
          rad_nxt = RAD_W'(sq_in);
          rem_nxt = '0; root_nxt = '0; quo_nxt = '0;
          cnt_nxt = 6'(ROOT_W);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_nxt  = u_rem;
        root_nxt = {root_r[ROOT_W-2:0], u_take};
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          state_nxt = ST_DIV;
          rem_nxt = '0;
          cnt_nxt = 6'(NUM_W);
        end
      end
      ST_DIV: begin
        if (root_r == '0) begin
          res_nxt = '0; ovf_nxt = 1'b0; dz_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          rem_nxt = u_rem;
          mag_nxt = {mag_r[NUM_W-2:0], 1'b0};
          quo_nxt = {quo_r[NUM_W-2:0], u_take};
          cnt_nxt = cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_nxt = ST_BIAS;
        end
      end
      ST_BIAS: begin
        // Restore the sign, add the bias and saturate
        qs = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
        vs = qs + (NUM_W+2)'($signed(aff_r[47:32]));
        dz_nxt = 1'b0;
        if (vs > 32767) begin
          res_nxt = 16'sh7FFF; ovf_nxt = 1'b1;
        end else if (vs < -32768) begin
          res_nxt = 16'sh8000; ovf_nxt = 1'b1;
        end else begin
          res_nxt = vs[15:0]; ovf_nxt = 1'b0;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; root_r <= root_nxt; rad_r <= rad_nxt; mag_r <= mag_nxt;
    quo_r <= quo_nxt; neg_r <= neg_nxt; res_r <= res_nxt; ovf_r <= ovf_nxt;
    dz_r <= dz_nxt;
  end

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.overflow && out_ch.divide_error)) else $error("flags");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.divide_error) |-> (out_ch.normalized == 16'sd0))
    else $error("divide error value");
endmodule
`default_nettype wire

[rtl/core/bn_shared_unit.sv]
// Shared shift/subtract unit: one step of bitwise square root or of
// restoring division per cycle. Depends on bn_pkg.
`default_nettype none
module bn_shared_unit
  import bn_pkg::*;
(
  input  wire logic [SQ_W+1:0]   rem_i,
  input  wire logic [SQ_W+1:0]   trial_i,
  output logic      [SQ_W+1:0]   rem_o,
  output logic                   take_o
);
  // Compare and subtract in one unit for both operations
  always_comb begin
    take_o = (rem_i >= trial_i);
    rem_o  = take_o ? (rem_i - trial_i) : rem_i;
  end
endmodule
`default_nettype wire
